// ===== rtl/cac_pkg.sv =====
// Shared types and codes for the clock/alarm/countdown block.
// No dependencies; clock_alarm_countdown and cac_hms_step import this package.
`default_nettype none

package cac_pkg;

    localparam int HOURS_W   = 5;
    localparam int MINUTES_W = 6;
    localparam int SECONDS_W = 6;
    localparam int ACTION_W  = 3;

    localparam logic [HOURS_W-1:0]   MAX_HOURS   = HOURS_W'(23);
    localparam logic [MINUTES_W-1:0] MAX_MINUTES = MINUTES_W'(59);
    localparam logic [SECONDS_W-1:0] MAX_SECONDS = SECONDS_W'(59);

    typedef enum logic [ACTION_W-1:0] {
        ACT_TICK       = 3'd0,
        ACT_SET_CLOCK  = 3'd1,
        ACT_SET_ALARM  = 3'd2,
        ACT_LOAD_TIMER = 3'd3,
        ACT_VIEW       = 3'd4,
        ACT_TOGGLE_SIG = 3'd5
    } t_action;

    typedef struct packed {
        logic [HOURS_W-1:0]   hours;
        logic [MINUTES_W-1:0] minutes;
        logic [SECONDS_W-1:0] seconds;
    } t_hms;

    typedef struct packed {
        logic [ACTION_W-1:0]  action;
        logic [HOURS_W-1:0]   value_hours;
        logic [MINUTES_W-1:0] value_minutes;
        logic [SECONDS_W-1:0] value_seconds;
    } t_req;

    typedef struct packed {
        logic [HOURS_W-1:0]   shown_hours;
        logic [MINUTES_W-1:0] shown_minutes;
        logic [SECONDS_W-1:0] shown_seconds;
        logic                 alarm_ring;
        logic                 timer_done;
        logic                 alarm_waiting;
        logic                 timer_ready;
        logic                 showing_timer;
        logic [8:0]           second_angle;
        logic [8:0]           minute_angle;
        logic [9:0]           hour_angle;
    } t_rsp;

endpackage

`default_nettype wire

// ===== rtl/cac_stream_if.sv =====
// Valid/ready stream channel carrying one payload of type T.
// Used with cac_pkg::t_req and cac_pkg::t_rsp.
`default_nettype none

interface cac_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== rtl/clock_alarm_countdown.sv =====
// Time-of-day clock with hour:minute alarm and h:m:s countdown, top level.
// Depends on cac_pkg, cac_stream_if and cac_hms_step.
//
// Each request carries one action: a tick (one second), set clock, set and
// arm the alarm, load and arm the countdown, press the view button or toggle
// the alarm signal. Every request yields exactly one response: the shown time
// (clock, or countdown while the timer view is active), the ring and done
// pulses, the status flags, and integer hand angles of the clock. Times are
// kept as separate hour, minute and second fields, so no division is needed
// anywhere; operands above range saturate (hours to 23, minutes and seconds
// to 59). The state registers and the response register load on the edge
// that accepts a request, and the response is visible the next cycle. The
// block takes one request per cycle, limited only by the response register:
// i_req.ready drops only while a response is held and o_rsp.ready is low. On
// the tick that brings the countdown to zero the response still shows the
// countdown at 00:00:00 before the view falls back to the clock.
`default_nettype none

module clock_alarm_countdown (
    input  logic         i_clk,
    input  logic         i_rst_n,
    cac_stream_if.sink   i_req,
    cac_stream_if.source o_rsp
);
    import cac_pkg::*;

    // architectural state
    t_hms                 r_clock,   n_clock;
    t_hms                 r_cd,      n_cd;
    logic [HOURS_W-1:0]   r_alarm_h, n_alarm_h;
    logic [MINUTES_W-1:0] r_alarm_m, n_alarm_m;
    logic r_cd_loaded,  n_cd_loaded;
    logic r_alarm_pend, n_alarm_pend;
    logic r_timer_pend, n_timer_pend;
    logic r_view,       n_view;
    logic r_ring_en,    n_ring_en;

    // response register
    logic r_out_valid;
    t_rsp r_rsp, n_rsp;

    logic accept;
    t_hms clock_inc, cd_dec, operand, shown;
    logic shown_view, ring, done;
    logic [3:0] tens_of_sec;
    t_action act;

    assign i_req.ready   = !r_out_valid || o_rsp.ready;
    assign accept        = i_req.valid && i_req.ready;
    assign o_rsp.valid   = r_out_valid;
    assign o_rsp.payload = r_rsp;

    // one-second steps of clock and countdown
    cac_hms_step u_clock_step (
        .i_time (r_clock),
        .i_down (1'b0),
        .o_time (clock_inc)
    );

    cac_hms_step u_cd_step (
        .i_time (r_cd),
        .i_down (1'b1),
        .o_time (cd_dec)
    );

    // saturate operands
    always_comb begin
        operand.hours   = (i_req.payload.value_hours > MAX_HOURS) ?
                          MAX_HOURS : i_req.payload.value_hours;
        operand.minutes = (i_req.payload.value_minutes > MAX_MINUTES) ?
                          MAX_MINUTES : i_req.payload.value_minutes;
        operand.seconds = (i_req.payload.value_seconds > MAX_SECONDS) ?
                          MAX_SECONDS : i_req.payload.value_seconds;
    end

    // next state for the accepted request
    always_comb begin
        act          = t_action'(i_req.payload.action);
        n_clock      = r_clock;
        n_cd         = r_cd;
        n_alarm_h    = r_alarm_h;
        n_alarm_m    = r_alarm_m;
        n_cd_loaded  = r_cd_loaded;
        n_alarm_pend = r_alarm_pend;
        n_timer_pend = r_timer_pend;
        n_view       = r_view;
        n_ring_en    = r_ring_en;
        ring         = 1'b0;
        done         = 1'b0;

        case (act)
            ACT_TICK: begin
                n_clock = clock_inc;
                if (r_cd_loaded) begin
                    n_cd = cd_dec;
                end
                // countdown hits zero: pulse, disarm, back to clock view
                if (r_cd_loaded && n_cd == '0) begin
                    done         = 1'b1;
                    n_timer_pend = 1'b0;
                    n_view       = 1'b0;
                end
                // alarm compares against the clock after this tick
                if (r_alarm_pend && r_alarm_h == n_clock.hours &&
                    r_alarm_m == n_clock.minutes) begin
                    n_alarm_pend = 1'b0;
                    ring         = r_ring_en;
                end
            end
            ACT_SET_CLOCK: begin
                n_clock = operand;
            end
            ACT_SET_ALARM: begin
                n_alarm_h    = operand.hours;
                n_alarm_m    = operand.minutes;
                n_alarm_pend = 1'b1;
            end
            ACT_LOAD_TIMER: begin
                n_cd         = operand;
                n_cd_loaded  = 1'b1;
                n_timer_pend = 1'b1;
            end
            ACT_VIEW: begin
                if (r_view) begin
                    n_view = 1'b0;
                end else if (r_timer_pend) begin
                    n_view = 1'b1;
                end
            end
            ACT_TOGGLE_SIG: begin
                n_ring_en = !r_ring_en;
            end
            default: begin
                // unused codes change nothing
            end
        endcase

        // a tick shows the view in force before the countdown check
        shown_view = (act == ACT_TICK) ? r_view : n_view;
    end

    // response fields
    always_comb begin
        shown = shown_view ? n_cd : n_clock;

        if (n_clock.seconds >= SECONDS_W'(50))      tens_of_sec = 4'd5;
        else if (n_clock.seconds >= SECONDS_W'(40)) tens_of_sec = 4'd4;
        else if (n_clock.seconds >= SECONDS_W'(30)) tens_of_sec = 4'd3;
        else if (n_clock.seconds >= SECONDS_W'(20)) tens_of_sec = 4'd2;
        else if (n_clock.seconds >= SECONDS_W'(10)) tens_of_sec = 4'd1;
        else                                        tens_of_sec = 4'd0;

        n_rsp.shown_hours   = shown.hours;
        n_rsp.shown_minutes = shown.minutes;
        n_rsp.shown_seconds = shown.seconds;
        n_rsp.alarm_ring    = ring;
        n_rsp.timer_done    = done;
        n_rsp.alarm_waiting = n_alarm_pend;
        n_rsp.timer_ready   = n_timer_pend;
        n_rsp.showing_timer = shown_view;
        n_rsp.second_angle  = 9'(n_clock.seconds) * 9'd6;
        n_rsp.minute_angle  = 9'(n_clock.minutes) * 9'd6 + 9'(tens_of_sec);
        n_rsp.hour_angle    = 10'(n_clock.hours) * 10'd30
                            + 10'(n_clock.minutes >> 1);
    end

    // state registers: advance only on an accepted request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clock      <= '0;
            r_cd         <= '0;
            r_alarm_h    <= '0;
            r_alarm_m    <= '0;
            r_cd_loaded  <= 1'b0;
            r_alarm_pend <= 1'b0;
            r_timer_pend <= 1'b0;
            r_view       <= 1'b0;
            r_ring_en    <= 1'b1;
        end else if (accept) begin
            r_clock      <= n_clock;
            r_cd         <= n_cd;
            r_alarm_h    <= n_alarm_h;
            r_alarm_m    <= n_alarm_m;
            r_cd_loaded  <= n_cd_loaded;
            r_alarm_pend <= n_alarm_pend;
            r_timer_pend <= n_timer_pend;
            r_view       <= n_view;
            r_ring_en    <= n_ring_en;
        end
    end

    // response register: load on accept, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rsp <= n_rsp;
        end
    end

    // timer view is only ever selected while the countdown is armed
    a_view_needs_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_view |-> (r_timer_pend && r_cd_loaded))
        else $error("timer view active without an armed countdown");

    a_done_disarms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_rsp.timer_done) |-> (!r_rsp.timer_ready && !r_view))
        else $error("countdown done but timer still armed");

    a_ring_disarms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_rsp.alarm_ring) |-> !r_rsp.alarm_waiting)
        else $error("alarm rang but is still pending");

    a_accept_gives_rsp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_out_valid)
        else $error("accepted request produced no response");

    a_no_state_change_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !accept |=> ($stable(r_clock) && $stable(r_cd) && $stable(r_view)))
        else $error("state changed without an accepted request");

endmodule

`default_nettype wire

// ===== rtl/cac_hms_step.sv =====
// One-second step of an h:m:s value, up or down, wrapping at 24 hours.
// Depends on cac_pkg (t_hms and field limits).
`default_nettype none

module cac_hms_step (
    input  cac_pkg::t_hms i_time,
    input  logic          i_down,
    output cac_pkg::t_hms o_time
);
    import cac_pkg::*;

    always_comb begin
        o_time = i_time;
        if (i_down) begin
            // borrow ripples from seconds up through hours
            if (i_time.seconds != '0) begin
                o_time.seconds = i_time.seconds - SECONDS_W'(1);
            end else begin
                o_time.seconds = MAX_SECONDS;
                if (i_time.minutes != '0) begin
                    o_time.minutes = i_time.minutes - MINUTES_W'(1);
                end else begin
                    o_time.minutes = MAX_MINUTES;
                    if (i_time.hours != '0) begin
                        o_time.hours = i_time.hours - HOURS_W'(1);
                    end else begin
                        o_time.hours = MAX_HOURS;
                    end
                end
            end
        end else begin
            if (i_time.seconds != MAX_SECONDS) begin
                o_time.seconds = i_time.seconds + SECONDS_W'(1);
            end else begin
                o_time.seconds = '0;
                if (i_time.minutes != MAX_MINUTES) begin
                    o_time.minutes = i_time.minutes + MINUTES_W'(1);
                end else begin
                    o_time.minutes = '0;
                    if (i_time.hours != MAX_HOURS) begin
                        o_time.hours = i_time.hours + HOURS_W'(1);
                    end else begin
                        o_time.hours = '0;
                    end
                end
            end
        end
    end

endmodule

`default_nettype wire
